// ----- rtl/psev_pkg.sv -----
// Package for the postfix stack evaluator.
// Holds the stack geometry, the operator codes and the shared enum types.
// No dependencies.
`default_nettype none

package psev_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int DIV_CNT_W   = $clog2(DATA_W);
    localparam int NUM_W       = 10;
    localparam int OP_W        = 3;

    // Token kinds.
    localparam logic REQ_NUMBER   = 1'b0;
    localparam logic REQ_OPERATOR = 1'b1;

    // Operator codes; every other code gives zero.
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;

    // Command for one stack cell.
    typedef enum logic [1:0] {
        C_HOLD,
        C_SHIFT_IN,
        C_SHIFT_UP
    } t_cell_cmd;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_WB,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/psev_cell.sv -----
// One cell of the shift-register operand stack.
// Depends on psev_pkg for the data width and the cell command type.
`default_nettype none

module psev_cell
    import psev_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cell_cmd         i_cmd,
    input  wire logic [DATA_W-1:0] i_from_top,
    input  wire logic [DATA_W-1:0] i_from_deep,
    output logic      [DATA_W-1:0] o_value
);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    // A push takes the entry nearer the top; a pop takes the deeper one.
    always_comb begin
        unique case (i_cmd)
            C_SHIFT_IN: n_value = i_from_top;
            C_SHIFT_UP: n_value = i_from_deep;
            default:    n_value = r_value;
        endcase
    end

    // Payload only, so no reset.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- rtl/psev_divider.sv -----
// Iterative signed divider for a positive divisor, one quotient bit a cycle.
// Depends on psev_pkg for the data width.
`default_nettype none

module psev_divider
    import psev_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DATA_W-1:0] i_dividend,
    input  wire logic [DATA_W-1:0] i_divisor,
    output logic                   o_done,
    output logic      [DATA_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_div;
    logic                 r_neg;
    logic [DATA_W:0]      w_rem_sh;
    logic [DATA_W:0]      w_trial;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign w_rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign w_trial  = w_rem_sh - {1'b0, r_div};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the magnitude of the dividend is divided, the sign restored at the end.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_div <= i_divisor;
            r_neg <= i_dividend[DATA_W-1];
        end else if (r_busy) begin
            if (!w_trial[DATA_W]) begin
                r_rem <= w_trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

`default_nettype wire

// ----- rtl/postfix_stack_evaluator.sv -----
// Top level of the postfix stack evaluator.
// Depends on psev_pkg, psev_cell and psev_divider.
//
// Evaluates a postfix expression one token per item on a stack of STACK_DEPTH
// 32-bit entries built as a row of shift cells, the top entry in the first
// cell. Every accepted token gives exactly one result item with the new top,
// the fill count and the empty-pop and dropped-push flags. A number token and
// an add, subtract, multiply or unknown operator pass through the EXEC, WB
// and OUT states to the output register; a divide by a positive operand also
// waits in DIV for the divider, which resolves one quotient bit a cycle. One
// token is worked on at a time; the next token is taken as soon as the
// previous result sits in the output register, even while that result is
// stalled. After reset the stack is empty and the block accepts at once.
`default_nettype none

module postfix_stack_evaluator
    import psev_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Token channel.
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic                    i_req_type,
    input  wire logic [NUM_W-1:0]        i_number_value,
    input  wire logic [OP_W-1:0]         i_op_code,
    // Result channel.
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic signed [DATA_W-1:0]     o_top_value,
    output logic        [CNT_W-1:0]      o_stack_count,
    output logic                         o_empty_pop,
    output logic                         o_push_dropped
);

    t_state             r_state;
    t_state             n_state;
    logic               r_req;
    logic [NUM_W-1:0]   r_num;
    logic [OP_W-1:0]    r_code;
    logic [CNT_W-1:0]   r_count;
    logic [DATA_W-1:0]  r_alu;
    logic               r_missing;
    logic               r_dropped;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_top;
    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_missing;
    logic               r_out_dropped;

    logic               w_accept;
    logic               w_out_free;
    logic               w_full;
    logic [DATA_W-1:0]  w_x;
    logic [DATA_W-1:0]  w_y;
    logic               w_y_pos;
    logic               w_is_div;
    logic [DATA_W-1:0]  w_alu;
    logic               w_div_start;
    logic               w_div_done;
    logic [DATA_W-1:0]  w_quotient;
    t_cell_cmd          w_cmd_top;
    t_cell_cmd          w_cmd_rest;
    logic [DATA_W-1:0]  w_cell [STACK_DEPTH];

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_full     = (r_count >= CNT_W'(STACK_DEPTH));

    // Operands: y is the top, x the one below; missing ones read as zero.
    assign w_y      = (r_count >= CNT_W'(1)) ? w_cell[0] : '0;
    assign w_x      = (r_count >= CNT_W'(2)) ? w_cell[1] : '0;
    assign w_y_pos  = !w_y[DATA_W-1] && (w_y != '0);
    assign w_is_div = (r_req == REQ_OPERATOR) && (r_code == OP_DIV);

    // Combinational arithmetic; a divide by a non-positive y gives zero.
    always_comb begin
        if (r_req == REQ_NUMBER) begin
            w_alu = DATA_W'(r_num);
        end else begin
            unique case (r_code)
                OP_ADD:  w_alu = w_x + w_y;
                OP_SUB:  w_alu = w_x - w_y;
                OP_MUL:  w_alu = w_x * w_y;
                default: w_alu = '0;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: n_state = (w_is_div && w_y_pos) ? S_DIV : S_WB;
            S_DIV:  if (w_div_done) n_state = S_WB;
            S_WB:   n_state = S_OUT;
            S_OUT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_in_stall  = 1'b1;
        w_div_start = 1'b0;
        w_cmd_top   = C_HOLD;
        w_cmd_rest  = C_HOLD;
        unique case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_EXEC: w_div_start = w_is_div && w_y_pos;
            S_WB: begin
                if (r_req == REQ_OPERATOR) begin
                    w_cmd_top  = C_SHIFT_IN;
                    w_cmd_rest = C_SHIFT_UP;
                end else if (!r_dropped) begin
                    w_cmd_top  = C_SHIFT_IN;
                    w_cmd_rest = C_SHIFT_IN;
                end
            end
            default: ;
        endcase
    end

    // Sequencer and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_WB) begin
                if (r_req == REQ_OPERATOR) begin
                    r_count <= (r_count < CNT_W'(2)) ? CNT_W'(1) : r_count - 1'b1;
                end else if (!r_dropped) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Token capture, arithmetic result and flags.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_req_type;
            r_num  <= i_number_value;
            r_code <= i_op_code;
        end
        if (r_state == S_EXEC) begin
            r_alu     <= w_alu;
            r_missing <= (r_req == REQ_OPERATOR) && (r_count < CNT_W'(2));
            r_dropped <= (r_req == REQ_NUMBER) && w_full;
        end else if ((r_state == S_DIV) && w_div_done) begin
            r_alu <= w_quotient;
        end
    end

    // Output register: valid is control, the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_top     <= (r_count == '0) ? '0 : w_cell[0];
            r_out_count   <= r_count;
            r_out_missing <= r_missing;
            r_out_dropped <= r_dropped;
        end
    end

    // Divider for the divide operator.
    psev_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_x),
        .i_divisor  (w_y),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // The stack: cell 0 holds the top, each cell talks to its two neighbours.
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_top_in;
        logic [DATA_W-1:0] w_deep_in;
        if (g == 0) begin : g_first
            assign w_top_in = r_alu;
        end else begin : g_inner
            assign w_top_in = w_cell[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_deep_in = w_cell[g];
        end else begin : g_body
            assign w_deep_in = w_cell[g+1];
        end
        psev_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       ((g == 0) ? w_cmd_top : w_cmd_rest),
            .i_from_top  (w_top_in),
            .i_from_deep (w_deep_in),
            .o_value     (w_cell[g])
        );
    end

    assign o_out_valid    = r_out_valid;
    assign o_top_value    = r_out_top;
    assign o_stack_count  = r_out_count;
    assign o_empty_pop    = r_out_missing;
    assign o_push_dropped = r_out_dropped;

endmodule

`default_nettype wire

// ----- rtl/psev_checker.sv -----
// Port-level checker for the postfix stack evaluator, bound to the top level.
// Depends on psev_pkg for the stack geometry.
`default_nettype none

module psev_checker
    import psev_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire logic [DATA_W-1:0]   o_top_value,
    input wire logic [CNT_W-1:0]    o_stack_count,
    input wire logic                o_empty_pop,
    input wire logic                o_push_dropped
);

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_top_value)
            && $stable(o_stack_count) && $stable(o_empty_pop) && $stable(o_push_dropped))
        else $error("stalled result item changed");

    // Only one token is worked on at a time.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted while a token is in flight");

    // A dropped push only happens on a full stack.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_push_dropped |-> o_stack_count == CNT_W'(STACK_DEPTH)
            && !o_empty_pop)
        else $error("push dropped although the stack was not full");

    // A missing operand leaves exactly the operator result on the stack.
    a_missing_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_empty_pop |-> o_stack_count == CNT_W'(1))
        else $error("empty pop left a wrong fill count");

    // An empty stack reports a zero top.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_stack_count == '0) |-> o_top_value == '0)
        else $error("empty stack reported a non-zero top");

endmodule

bind postfix_stack_evaluator psev_checker u_psev_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_top_value    (o_top_value),
    .o_stack_count  (o_stack_count),
    .o_empty_pop    (o_empty_pop),
    .o_push_dropped (o_push_dropped)
);

`default_nettype wire

// ----- sim/postfix_stack_evaluator_tb.sv -----
// Self-checking testbench for the postfix stack evaluator.
// Depends on psev_pkg and postfix_stack_evaluator. Tokens are predicted on
// acceptance and each result item is checked field by field, under random idling.
`timescale 1ns / 100ps

module postfix_stack_evaluator_tb;
    import psev_pkg::*;

    localparam int LIMIT_CYCLES   = 400000;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int SETTLE_CYCLES  = 45;
    localparam int MAX_NUMBER     = 999;
    // Codes 4 to 7 are operators that the block does not know.
    localparam logic [OP_W-1:0] OP_UNKNOWN_LO = 3'd4;
    localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 3'd7;

    // One result item as the block should report it.
    typedef struct {
        logic signed [DATA_W-1:0] top;
        logic        [CNT_W-1:0]  count;
        logic                     empty_pop;
        logic                     push_dropped;
    } t_stack_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_req_type;
    logic [NUM_W-1:0]         i_number_value;
    logic [OP_W-1:0]          i_op_code;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [DATA_W-1:0] o_top_value;
    logic        [CNT_W-1:0]  o_stack_count;
    logic                     o_empty_pop;
    logic                     o_push_dropped;

    // Predicted stack contents and the results still to come.
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    int                stack_fill;
    t_stack_result     pending_results [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_left;
    int cycle_count;
    int mismatch_count;
    int tokens_sent;
    int divide_count;
    int empty_pop_count;
    int dropped_count;
    int deepest_fill;

    postfix_stack_evaluator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_number_value (i_number_value),
        .i_op_code      (i_op_code),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_top_value    (o_top_value),
        .o_stack_count  (o_stack_count),
        .o_empty_pop    (o_empty_pop),
        .o_push_dropped (o_push_dropped)
    );

    always #5 i_clk = ~i_clk;

    // The run is cut short if it takes far longer than any correct run could.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side: a long hold-off when one is requested, random stalls otherwise.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    // Each accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_stack_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result top=%0d count=%0d empty_pop=%0b dropped=%0b",
                         $time, o_top_value, o_stack_count, o_empty_pop, o_push_dropped);
            end else begin
                want = pending_results.pop_front();
                if (o_top_value !== want.top || o_stack_count !== want.count ||
                        o_empty_pop !== want.empty_pop ||
                        o_push_dropped !== want.push_dropped) begin
                    mismatch_count++;
                    $display({"%0t: mismatch expected top=%0d count=%0d empty_pop=%0b ",
                              "dropped=%0b, actual top=%0d count=%0d empty_pop=%0b ",
                              "dropped=%0b"},
                             $time, want.top, want.count, want.empty_pop,
                             want.push_dropped, o_top_value, o_stack_count,
                             o_empty_pop, o_push_dropped);
                end
            end
        end
    end

    // Takes one operand off the predicted stack; an empty stack gives zero.
    function automatic logic [DATA_W-1:0] pop_operand(inout logic missing);
        if (stack_fill == 0) begin
            missing = 1'b1;
            return '0;
        end
        stack_fill--;
        return stack_mem[stack_fill];
    endfunction

    // Applies one token to the predicted stack and returns the result it gives.
    function automatic t_stack_result eval_token(input logic req,
                                                 input logic [NUM_W-1:0] num,
                                                 input logic [OP_W-1:0] op);
        t_stack_result     res;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic              missing;
        missing = 1'b0;
        res.push_dropped = 1'b0;
        z = '0;
        if (req == REQ_NUMBER) begin
            if (stack_fill < STACK_DEPTH) begin
                stack_mem[stack_fill] = {{(DATA_W-NUM_W){1'b0}}, num};
                stack_fill++;
            end else begin
                res.push_dropped = 1'b1;
            end
        end else begin
            y = pop_operand(missing);
            x = pop_operand(missing);
            case (op)
                OP_ADD: z = x + y;
                OP_SUB: z = x - y;
                OP_MUL: z = x * y;
                OP_DIV: begin
                    // Truncates toward zero; a divisor that is not positive gives zero.
                    if ($signed(y) > 0) begin
                        z = $signed(x) / $signed(y);
                        divide_count++;
                    end
                end
                default: z = '0;
            endcase
            // Two pops always leave room for the result.
            stack_mem[stack_fill] = z;
            stack_fill++;
        end
        res.empty_pop = missing;
        res.top = (stack_fill > 0) ? stack_mem[stack_fill-1] : '0;
        res.count = CNT_W'(stack_fill);
        empty_pop_count += missing;
        dropped_count += res.push_dropped;
        if (stack_fill > deepest_fill) begin
            deepest_fill = stack_fill;
        end
        return res;
    endfunction

    // Offers one item, idling first at random, and predicts it once accepted.
    task automatic send_token(input logic req, input logic [NUM_W-1:0] num,
                              input logic [OP_W-1:0] op);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_number_value <= num;
        i_op_code      <= op;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pending_results.push_back(eval_token(req, num, op));
        tokens_sent++;
    endtask

    // Stops offering items until every predicted result has been checked.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [NUM_W-1:0] pick_number();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            return '0;
        end else if (roll < 16) begin
            return NUM_W'(MAX_NUMBER);
        end else if (roll < 35) begin
            return NUM_W'($urandom_range(1, 9));
        end
        return NUM_W'($urandom_range(0, MAX_NUMBER));
    endfunction

    function automatic logic [OP_W-1:0] pick_operator();
        if ($urandom_range(0, 99) < 8) begin
            return OP_W'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
        end
        return OP_W'($urandom_range(OP_ADD, OP_DIV));
    endfunction

    // Mostly well-formed expressions with random content, plus stray tokens.
    task automatic run_expressions(input int n_tokens);
        int stop_at;
        int operands;
        int open_terms;
        stop_at = tokens_sent + n_tokens;
        while (tokens_sent < stop_at) begin
            if ($urandom_range(0, 99) < 15) begin
                send_token(1'($urandom_range(0, 1)), pick_number(),
                           OP_W'($urandom_range(0, 7)));
            end else if (stack_fill > 40) begin
                send_token(REQ_OPERATOR, '0, pick_operator());
            end else begin
                operands = $urandom_range(1, 10);
                open_terms = 0;
                while (operands > 0 || open_terms > 1) begin
                    if (operands > 0 && (open_terms < 2 || $urandom_range(0, 1) == 1)) begin
                        send_token(REQ_NUMBER, pick_number(), OP_ADD);
                        operands--;
                        open_terms++;
                    end else begin
                        send_token(REQ_OPERATOR, '0, pick_operator());
                        open_terms--;
                    end
                end
                // Half the time fold the value into what the stack already holds.
                if (stack_fill >= 2 && $urandom_range(0, 1) == 1) begin
                    send_token(REQ_OPERATOR, '0, pick_operator());
                end
            end
        end
    endtask

    // Operators on an empty stack and on a single entry.
    task automatic test_empty_stack();
        send_token(REQ_OPERATOR, '0, OP_ADD);
        send_token(REQ_OPERATOR, '0, OP_DIV);
    endtask

    // Add and subtract, truncating division, division by zero and by a negative value,
    // and every unknown operator code.
    task automatic test_operators();
        send_token(REQ_NUMBER, NUM_W'(7), OP_ADD);
        send_token(REQ_NUMBER, NUM_W'(3), OP_ADD);
        send_token(REQ_OPERATOR, '0, OP_ADD);
        send_token(REQ_NUMBER, NUM_W'(10), OP_ADD);
        send_token(REQ_OPERATOR, '0, OP_SUB);
        send_token(REQ_NUMBER, NUM_W'(3), OP_ADD);
        send_token(REQ_OPERATOR, '0, OP_SUB);
        send_token(REQ_NUMBER, NUM_W'(2), OP_ADD);
        send_token(REQ_OPERATOR, '0, OP_DIV);
        send_token(REQ_NUMBER, '0, OP_ADD);
        send_token(REQ_OPERATOR, '0, OP_DIV);
        send_token(REQ_NUMBER, NUM_W'(1), OP_ADD);
        send_token(REQ_NUMBER, NUM_W'(2), OP_ADD);
        send_token(REQ_OPERATOR, '0, OP_SUB);
        send_token(REQ_OPERATOR, '0, OP_DIV);
        for (int code = OP_UNKNOWN_LO; code <= OP_UNKNOWN_HI; code++) begin
            send_token(REQ_NUMBER, NUM_W'(MAX_NUMBER), OP_ADD);
            send_token(REQ_OPERATOR, '0, OP_W'(code));
        end
    endtask

    // Repeated products of the largest number wrap past 32 bits.
    task automatic test_wraparound();
        send_token(REQ_NUMBER, NUM_W'(MAX_NUMBER), OP_ADD);
        repeat (3) begin
            send_token(REQ_NUMBER, NUM_W'(MAX_NUMBER), OP_ADD);
            send_token(REQ_OPERATOR, '0, OP_MUL);
        end
        wait_drained();
    endtask

    // The result side holds off while numbers keep coming, so the block backs up;
    // the stack fills, further pushes are dropped, and operators then drain it.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        @(posedge i_clk);
        hold_left = HOLD_OFF_LEN;
        repeat (STACK_DEPTH + 16) begin
            send_token(REQ_NUMBER, pick_number(), OP_ADD);
        end
        while (stack_fill > 2) begin
            send_token(REQ_OPERATOR, '0, pick_operator());
        end
        wait_drained();
    endtask

    // Random expressions under each idling pattern.
    task automatic test_random_phases();
        int sender_pct [4]   = '{0, 57, 0, 35};
        int receiver_pct [4] = '{0, 0, 57, 35};
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = sender_pct[p];
            receiver_stall_pct = receiver_pct[p];
            run_expressions(150);
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = REQ_NUMBER;
        i_number_value = '0;
        i_op_code = OP_ADD;
        i_out_stall = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_left = 0;
        cycle_count = 0;
        mismatch_count = 0;
        tokens_sent = 0;
        divide_count = 0;
        empty_pop_count = 0;
        dropped_count = 0;
        deepest_fill = 0;
        stack_fill = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_stack();
        test_operators();
        test_wraparound();
        test_backpressure();
        test_random_phases();

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d tokens with %0d true divisions, %0d empty pops and %0d dropped",
                 tokens_sent, divide_count, empty_pop_count, dropped_count);
        $display("pushes; deepest stack %0d, under four idling patterns and a long hold-off.",
                 deepest_fill);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
